/* sv/ils_pkg.sv */
package ils_pkg;

  // default storage shape
  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // fixed port field widths
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned INDEX_W  = 4;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 3'd0,
    CMD_POP   = 3'd1,
    CMD_ERASE = 3'd2,
    CMD_READ  = 3'd3,
    CMD_WRITE = 3'd4,
    CMD_CLEAR = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

endpackage

/* sv/indexed_list_store.sv */
// channel | direction | handshake            | payload
// in_     | input     | in_valid / in_stall  | in_cmd, in_index, in_value
// out_    | output    | out_valid / out_stall| out_read_value, out_count, out_status
//
// push, pop, write, clear, unused codes and any rejected command finish in the accept cycle
// read goes through state S_RD: one registered read of the entry memory
// erase steps through S_ER_RD and S_ER_WR for each later entry, then S_FIN: each later entry moves down
// through the one read port and the one write port of the entry memory
// reset (synchronous, rst_n low) empties the list; the entry memory is not cleared
// a result waits in the output register; no new transaction is taken while it is stalled
module indexed_list_store #(
  parameter int unsigned DEPTH      = ils_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = ils_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ils_pkg::CMD_W-1:0]     in_cmd,
  input  logic [ils_pkg::INDEX_W-1:0]   in_index,
  input  logic [ils_pkg::VALUE_W-1:0]   in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ils_pkg::VALUE_W-1:0]   out_read_value,
  output logic [ils_pkg::COUNT_W-1:0]   out_count,
  output logic [ils_pkg::STATUS_W-1:0]  out_status
);
  import ils_pkg::*;

  // address bits for the memory, count bits that can hold DEPTH itself
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_ER_RD,
    S_ER_WR,
    S_FIN
  } state_t;

  state_t               state_r;
  logic [CW-1:0]        count_r;
  logic [CW-1:0]        addr_r;
  logic                 out_valid_r;
  logic [VALUE_W-1:0]   out_read_value_r;
  logic [CW-1:0]        out_count_r;
  status_t              out_status_r;

  // entry memory, one write and one registered read per cycle
  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_r;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]         mem_raddr;

  logic                  in_fire;
  logic                  slot_free;
  logic [CW+INDEX_W-1:0] idx_wide;
  logic [CW+INDEX_W-1:0] cnt_wide;
  logic                  idx_ok;
  logic [DATA_WIDTH+VALUE_W-1:0] val_in_wide;
  logic [DATA_WIDTH-1:0]         val_in;
  logic [DATA_WIDTH+VALUE_W-1:0] rd_out_wide;
  logic [CW+COUNT_W-1:0]         out_cnt_wide;
  logic [CW-1:0]                 addr_inc;
  logic                          shift_more;

  // output slot can take a new result this cycle
  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE) || !slot_free;
  assign in_fire   = in_valid && !in_stall;

  // index range check at a common width
  assign idx_wide = {{CW{1'b0}}, in_index};
  assign cnt_wide = {{INDEX_W{1'b0}}, count_r};
  assign idx_ok   = idx_wide < cnt_wide;

  // fit the port word to the stored width and back
  assign val_in_wide = {{DATA_WIDTH{1'b0}}, in_value};
  assign val_in      = val_in_wide[DATA_WIDTH-1:0];
  assign rd_out_wide = {{VALUE_W{1'b0}}, rdata_r};

  // erase walk: next source entry and whether one is left
  assign addr_inc   = addr_r + ONE_C;
  assign shift_more = addr_inc < count_r;

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_r[AW-1:0];
    mem_wdata = rdata_r;
    mem_raddr = addr_r[AW-1:0];
    unique case (state_r)
      S_IDLE: begin
        mem_raddr = idx_wide[AW-1:0];
        if (in_fire && in_cmd == CMD_PUSH && count_r < DEPTH_C) begin
          mem_we    = 1'b1;
          mem_waddr = count_r[AW-1:0];
          mem_wdata = val_in;
        end else if (in_fire && in_cmd == CMD_WRITE && idx_ok) begin
          mem_we    = 1'b1;
          mem_waddr = idx_wide[AW-1:0];
          mem_wdata = val_in;
        end
      end
      S_ER_RD: begin
        mem_raddr = addr_inc[AW-1:0];
      end
      S_ER_WR: begin
        // data of entry addr_r + 1 moves down to addr_r
        mem_we = 1'b1;
      end
      S_RD, S_FIN: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  // sequencer, count and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      addr_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            // default result: done on acceptance, no read data
            out_valid_r      <= 1'b1;
            out_read_value_r <= '0;
            out_status_r     <= ST_OK;
            out_count_r      <= count_r;
            addr_r           <= idx_wide[CW-1:0];
            unique case (in_cmd)
              CMD_PUSH: begin
                if (count_r < DEPTH_C) begin
                  count_r     <= count_r + ONE_C;
                  out_count_r <= count_r + ONE_C;
                end else begin
                  out_status_r <= ST_FULL;
                end
              end
              CMD_POP: begin
                if (count_r != '0) begin
                  count_r     <= count_r - ONE_C;
                  out_count_r <= count_r - ONE_C;
                end else begin
                  out_status_r <= ST_EMPTY;
                end
              end
              CMD_ERASE: begin
                if (idx_ok) begin
                  out_valid_r <= 1'b0;
                  state_r     <= S_ER_RD;
                end else begin
                  out_status_r <= ST_RANGE;
                end
              end
              CMD_READ: begin
                if (idx_ok) begin
                  out_valid_r <= 1'b0;
                  state_r     <= S_RD;
                end else begin
                  out_status_r <= ST_RANGE;
                end
              end
              CMD_WRITE: begin
                if (!idx_ok) begin
                  out_status_r <= ST_RANGE;
                end
              end
              CMD_CLEAR: begin
                count_r     <= '0;
                out_count_r <= '0;
              end
              default: begin
                // unused codes leave the list as it is
              end
            endcase
          end
        end
        S_RD: begin
          if (slot_free) begin
            out_valid_r      <= 1'b1;
            out_read_value_r <= rd_out_wide[VALUE_W-1:0];
            out_count_r      <= count_r;
            out_status_r     <= ST_OK;
            state_r          <= S_IDLE;
          end
        end
        S_ER_RD: begin
          if (shift_more) begin
            state_r <= S_ER_WR;
          end else begin
            count_r <= count_r - ONE_C;
            state_r <= S_FIN;
          end
        end
        S_ER_WR: begin
          addr_r  <= addr_inc;
          state_r <= S_ER_RD;
        end
        S_FIN: begin
          if (slot_free) begin
            out_valid_r      <= 1'b1;
            out_read_value_r <= '0;
            out_count_r      <= count_r;
            out_status_r     <= ST_OK;
            state_r          <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_cnt_wide   = {{COUNT_W{1'b0}}, out_count_r};
  assign out_valid      = out_valid_r;
  assign out_read_value = out_read_value_r;
  assign out_count      = out_cnt_wide[COUNT_W-1:0];
  assign out_status     = out_status_r;

  // the list never holds more than DEPTH entries
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("entry count above depth");

  // an accepted push on a non-full list grows the count by one
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_cmd == CMD_PUSH && count_r < DEPTH_C
    |=> count_r == $past(count_r) + ONE_C)
    else $error("push did not grow the list");

  // an erase move only copies from an entry that is held
  a_erase_src: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ER_WR |-> addr_inc < count_r)
    else $error("erase move past the tail");

  // the count is stable while a read or an erase is in the memory walk
  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ER_WR || state_r == S_RD |=> $stable(count_r))
    else $error("count changed during memory walk");

  // a reported result never shows more entries than the depth
  a_out_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_count_r <= DEPTH_C)
    else $error("result count above depth");

endmodule

/* sim/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ils_pkg::*;

  localparam realtime     CLK_PERIOD  = 2ns;
  localparam int unsigned LIST_DEPTH  = DEPTH_DEF;
  localparam int unsigned STALL_LIMIT = 4000;  // cycles without any transaction
  localparam int unsigned TAIL_CYCLES = 64;    // outlasts the longest erase
  localparam int unsigned PHASE_ITEMS = 400;
  localparam int unsigned MAX_REPORTS = 40;

  // command codes the block must ignore
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  // table column: expected result typed in, or taken from the list model
  localparam bit KNOWN   = 1'b1;
  localparam bit PREDICT = 1'b0;

  typedef struct packed {
    logic [VALUE_W-1:0] read_value;
    logic [COUNT_W-1:0] count;
    status_t            status;
  } list_result_t;

  typedef struct {
    logic [CMD_W-1:0]   code;
    logic [INDEX_W-1:0] idx;
    logic [VALUE_W-1:0] word;
    int unsigned        reps;   // repeated rows add the repeat number to the word
    bit                 known;
    list_result_t       want;
  } stim_row_t;

  // clock, reset and every block input start at a known value
  logic               clk      = 1'b0;
  logic               rst_n    = 1'b0;
  logic               in_valid = 1'b0;
  logic [CMD_W-1:0]   in_cmd   = '0;
  logic [INDEX_W-1:0] in_index = '0;
  logic [VALUE_W-1:0] in_value = '0;
  logic               out_stall = 1'b0;

  logic                in_stall;
  logic                out_valid;
  logic [VALUE_W-1:0]  out_read_value;
  logic [COUNT_W-1:0]  out_count;
  logic [STATUS_W-1:0] out_status;

  // list model state: words and fill level after every accepted transaction
  logic [VALUE_W-1:0] list_words [LIST_DEPTH];
  int unsigned        list_count = 0;

  list_result_t awaited_results [$];
  stim_row_t    directed_rows [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned error_count   = 0;
  int unsigned results_seen  = 0;
  int unsigned idle_cycles   = 0;
  int unsigned cmd_tally [8];
  int unsigned status_tally [4];

  indexed_list_store i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_index      (in_index),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_read_value(out_read_value),
    .out_count     (out_count),
    .out_status    (out_status)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // list model: applies one command and returns the result it must produce
  function automatic list_result_t apply_list_cmd(input logic [CMD_W-1:0] code,
                                                  input logic [INDEX_W-1:0] idx,
                                                  input logic [VALUE_W-1:0] word);
    list_result_t res;
    bit           in_range;
    res.read_value = '0;
    res.status     = ST_OK;
    in_range       = idx < list_count;
    case (code)
      CMD_PUSH: begin
        if (list_count >= LIST_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          list_words[list_count] = word;
          list_count++;
        end
      end
      CMD_POP: begin
        if (list_count == 0) res.status = ST_EMPTY;
        else list_count--;
      end
      CMD_ERASE: begin
        if (!in_range) begin
          res.status = ST_RANGE;
        end else begin
          // later entries close the gap
          for (int unsigned i = idx; i + 1 < list_count; i++) list_words[i] = list_words[i + 1];
          list_count--;
        end
      end
      CMD_READ: begin
        if (!in_range) res.status = ST_RANGE;
        else res.read_value = list_words[idx];
      end
      CMD_WRITE: begin
        if (!in_range) res.status = ST_RANGE;
        else list_words[idx] = word;
      end
      CMD_CLEAR: list_count = 0;
      default: ;  // spare codes leave everything as it is
    endcase
    res.count = list_count[COUNT_W-1:0];
    return res;
  endfunction

  function automatic void plan(input logic [CMD_W-1:0] code, input logic [INDEX_W-1:0] idx,
                               input logic [VALUE_W-1:0] word, input int unsigned reps,
                               input bit known, input logic [VALUE_W-1:0] rd,
                               input logic [COUNT_W-1:0] cnt, input status_t st);
    stim_row_t row;
    row.code            = code;
    row.idx             = idx;
    row.word            = word;
    row.reps            = reps;
    row.known           = known;
    row.want.read_value = rd;
    row.want.count      = cnt;
    row.want.status     = st;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  // mostly an entry that exists, now and then any position
  function automatic logic [INDEX_W-1:0] pick_index();
    if (list_count > 0 && $urandom_range(9) != 0)
      return INDEX_W'($urandom_range(list_count - 1));
    return INDEX_W'($urandom_range((1 << INDEX_W) - 1));
  endfunction

  function automatic logic [VALUE_W-1:0] pick_word();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return 32'd1 << $urandom_range(VALUE_W - 1);
      3: return ~(32'd1 << $urandom_range(VALUE_W - 1));
      default: return $urandom;
    endcase
  endfunction

  // one input transaction: random gap, drive, wait for acceptance, predict
  task automatic send_item(input logic [CMD_W-1:0] code, input logic [INDEX_W-1:0] idx,
                           input logic [VALUE_W-1:0] word, input bit known = PREDICT,
                           input list_result_t want = '0);
    list_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd   <= code;
    in_index <= idx;
    in_value <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // model runs on every accepted transaction, even when the row has a typed result
    predicted = apply_list_cmd(code, idx, word);
    awaited_results.insert(awaited_results.size(), known ? want : predicted);
    cmd_tally[code]++;
  endtask

  // hold off the sender until every outstanding result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
  endtask

  // state-aware traffic; spare codes are sent but not counted
  task automatic run_random_traffic(input int unsigned budget);
    int unsigned      sent;
    int unsigned      reps;
    int unsigned      pick;
    logic [CMD_W-1:0] code;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(99);
      if (pick < 2) begin
        drain_results();
      end else if (pick < 30) begin
        // fill toward the top, sometimes past it
        reps = $urandom_range(LIST_DEPTH + 1 - list_count, 1);
        repeat (reps) begin
          send_item(CMD_PUSH, INDEX_W'($urandom_range((1 << INDEX_W) - 1)), pick_word());
          sent++;
        end
      end else if (pick < 60) begin
        // indexed accesses: reads, writes and erases
        reps = $urandom_range(10, 3);
        repeat (reps) begin
          pick = $urandom_range(4);
          code = (pick < 2) ? CMD_READ : (pick < 4) ? CMD_WRITE : CMD_ERASE;
          send_item(code, pick_index(), pick_word());
          sent++;
        end
      end else if (pick < 75) begin
        // unwind, occasionally past empty
        reps = $urandom_range(list_count + 2, 1);
        repeat (reps) begin
          send_item(CMD_POP, INDEX_W'($urandom_range((1 << INDEX_W) - 1)), $urandom);
          sent++;
        end
      end else if (pick < 80) begin
        send_item(CMD_CLEAR, INDEX_W'($urandom_range((1 << INDEX_W) - 1)), $urandom);
        sent++;
      end else if (pick < 88) begin
        // noise: any code, any index, any word
        code = CMD_W'($urandom_range(7));
        send_item(code, INDEX_W'($urandom_range((1 << INDEX_W) - 1)), $urandom);
        if (code < CMD_SPARE_LO) sent++;
      end else begin
        code = CMD_W'($urandom_range(CMD_WRITE));
        send_item(code, pick_index(), pick_word());
        sent++;
      end
    end
  endtask

  task automatic flag_field(input string what, input logic [VALUE_W-1:0] want,
                            input logic [VALUE_W-1:0] got);
    if (got !== want) begin
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
    end
  endtask

  // receiver: stalls at random at the current rate
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // result checker: every accepted result against the oldest expectation
  always @(posedge clk) begin : check_results
    list_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (awaited_results.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t: result with none expected, actual value 0x%0h count %0d status %0d",
                   $time, out_read_value, out_count, out_status);
      end else begin
        want = awaited_results.pop_front();
        status_tally[want.status]++;
        flag_field("read_value", want.read_value, out_read_value);
        flag_field("count", VALUE_W'(want.count), VALUE_W'(out_count));
        flag_field("status", VALUE_W'(want.status), VALUE_W'(out_status));
      end
    end
  end

  // watchdog: a stretch with no transaction on either channel ends the run
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, awaited_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    // directed table: empty-list errors, extreme words and indexes, spare codes,
    // full push, longest erase shift, erase of the tail, clear
    plan(CMD_POP,      4'd0,  32'h0000_0000, 1,  KNOWN,   32'h0000_0000, 5'd0,  ST_EMPTY);
    plan(CMD_READ,     4'd0,  32'h0000_0000, 1,  KNOWN,   32'h0000_0000, 5'd0,  ST_RANGE);
    plan(CMD_ERASE,    4'd15, 32'h0000_0000, 1,  KNOWN,   32'h0000_0000, 5'd0,  ST_RANGE);
    plan(CMD_WRITE,    4'd15, 32'hFFFF_FFFF, 1,  KNOWN,   32'h0000_0000, 5'd0,  ST_RANGE);
    plan(CMD_SPARE_HI, 4'd15, 32'hFFFF_FFFF, 1,  KNOWN,   32'h0000_0000, 5'd0,  ST_OK);
    plan(CMD_PUSH,     4'd15, 32'hFFFF_FFFF, 1,  KNOWN,   32'h0000_0000, 5'd1,  ST_OK);
    plan(CMD_PUSH,     4'd0,  32'h0000_0000, 1,  KNOWN,   32'h0000_0000, 5'd2,  ST_OK);
    plan(CMD_READ,     4'd0,  32'h0000_0000, 1,  KNOWN,   32'hFFFF_FFFF, 5'd2,  ST_OK);
    plan(CMD_READ,     4'd1,  32'hFFFF_FFFF, 1,  KNOWN,   32'h0000_0000, 5'd2,  ST_OK);
    plan(CMD_READ,     4'd2,  32'h0000_0000, 1,  KNOWN,   32'h0000_0000, 5'd2,  ST_RANGE);
    plan(CMD_SPARE_LO, 4'd0,  32'h0000_0000, 1,  KNOWN,   32'h0000_0000, 5'd2,  ST_OK);
    plan(CMD_WRITE,    4'd1,  32'h5A5A_5A5A, 1,  PREDICT, 32'h0000_0000, 5'd0,  ST_OK);
    plan(CMD_ERASE,    4'd0,  32'h0000_0000, 1,  PREDICT, 32'h0000_0000, 5'd0,  ST_OK);
    plan(CMD_CLEAR,    4'd0,  32'h0000_0000, 1,  KNOWN,   32'h0000_0000, 5'd0,  ST_OK);
    plan(CMD_PUSH,     4'd0,  32'h1000_0000, 16, PREDICT, 32'h0000_0000, 5'd0,  ST_OK);
    plan(CMD_PUSH,     4'd0,  32'hDEAD_BEEF, 1,  KNOWN,   32'h0000_0000, 5'd16, ST_FULL);
    plan(CMD_READ,     4'd15, 32'h0000_0000, 1,  PREDICT, 32'h0000_0000, 5'd0,  ST_OK);
    plan(CMD_ERASE,    4'd0,  32'h0000_0000, 1,  PREDICT, 32'h0000_0000, 5'd0,  ST_OK);
    plan(CMD_READ,     4'd15, 32'h0000_0000, 1,  KNOWN,   32'h0000_0000, 5'd15, ST_RANGE);
    plan(CMD_WRITE,    4'd14, 32'hFFFF_FFFF, 1,  PREDICT, 32'h0000_0000, 5'd0,  ST_OK);
    plan(CMD_ERASE,    4'd14, 32'h0000_0000, 1,  PREDICT, 32'h0000_0000, 5'd0,  ST_OK);
    plan(CMD_POP,      4'd0,  32'h0000_0000, 1,  PREDICT, 32'h0000_0000, 5'd0,  ST_OK);
    plan(CMD_READ,     4'd0,  32'h0000_0000, 1,  PREDICT, 32'h0000_0000, 5'd0,  ST_OK);
    plan(CMD_CLEAR,    4'd7,  32'h0000_0000, 1,  KNOWN,   32'h0000_0000, 5'd0,  ST_OK);
    plan(CMD_POP,      4'd0,  32'h0000_0000, 1,  KNOWN,   32'h0000_0000, 5'd0,  ST_EMPTY);

    // single synchronous reset at the start
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // first phase: sender gap chance 35 percent, receiver stall chance 88 percent
    send_idle_pct = 35;
    recv_idle_pct = 88;
    foreach (directed_rows[r]) begin
      for (int unsigned k = 0; k < directed_rows[r].reps; k++)
        send_item(directed_rows[r].code, directed_rows[r].idx, directed_rows[r].word + k,
                  directed_rows[r].known, directed_rows[r].want);
    end
    drain_results();
    run_random_traffic(PHASE_ITEMS);
    drain_results();

    // second phase: the rates swap over
    send_idle_pct = 88;
    recv_idle_pct = 35;
    run_random_traffic(PHASE_ITEMS);
    drain_results();

    // last phase: back to back on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_traffic(PHASE_ITEMS);
    drain_results();

    // quiet tail so a stray result still shows up
    repeat (TAIL_CYCLES) @(posedge clk);
    if (awaited_results.size() != 0) begin
      error_count++;
      $display("%0t: %0d expected results never arrived", $time, awaited_results.size());
    end

    $display("covered push %0d, pop %0d, erase %0d, read %0d, write %0d, clear %0d, spare %0d",
             cmd_tally[CMD_PUSH], cmd_tally[CMD_POP], cmd_tally[CMD_ERASE],
             cmd_tally[CMD_READ], cmd_tally[CMD_WRITE], cmd_tally[CMD_CLEAR],
             cmd_tally[CMD_SPARE_LO] + cmd_tally[CMD_SPARE_HI]);
    $display("%0d results checked: full %0d, empty %0d, out of range %0d, %0d errors",
             results_seen, status_tally[ST_FULL], status_tally[ST_EMPTY],
             status_tally[ST_RANGE], error_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
